FILE: sv/spdq_pkg.sv
// ----------------------------------------------------------------------------
// spdq_pkg
// Shared types and codes for the sign-partitioned deque: action and status
// codes, and the control word that drives a row of storage cells.
// ----------------------------------------------------------------------------
package spdq_pkg;

	localparam int DATA_W   = 32;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam logic [ACTION_W-1:0] ACT_INSERT     = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   data;
	} cell_ctrl_t;

endpackage

FILE: sv/spdq_cell.sv
// ----------------------------------------------------------------------------
// spdq_cell
// One storage cell of a row. It holds one entry and, every cycle, keeps it,
// takes the value of its left or right neighbor, or loads the insert value.
// ----------------------------------------------------------------------------
module spdq_cell #(
	parameter int IDX = 0,
	parameter int IW  = 1
) (
	input  logic                                clk,
	input  spdq_pkg::cell_ctrl_t                ctrl,
	input  logic [IW-1:0]                       pos,
	input  logic [spdq_pkg::DATA_W-1:0]         left,
	input  logic [spdq_pkg::DATA_W-1:0]         right,
	output logic [spdq_pkg::DATA_W-1:0]         data
);
	import spdq_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] next_w;

	always_comb begin
		next_w = data_q;
		case (ctrl.op)
			OP_INSERT: begin
				// Cells above the insert point make room by taking their left neighbor.
				if (MY_IDX == pos) begin
					next_w = ctrl.data;
				end else if (MY_IDX > pos) begin
					next_w = left;
				end
			end
			OP_SHIFT: begin
				next_w = right;
			end
			default: begin
				next_w = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= next_w;
	end

	assign data = data_q;

endmodule

FILE: sv/spdq_row.sv
// ----------------------------------------------------------------------------
// spdq_row
// A row of DEPTH cells chained to their neighbors. The row opens a slot at any
// position, or shifts everything one place toward cell 0.
// ----------------------------------------------------------------------------
module spdq_row #(
	parameter int DEPTH = 64,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic                            clk,
	input  spdq_pkg::cell_ctrl_t            ctrl,
	input  logic [IW-1:0]                   pos,
	output logic [spdq_pkg::DATA_W-1:0]     head
);
	import spdq_pkg::*;

	logic [DATA_W-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w;
		logic [DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_inner_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner_r
			assign right_w = cell_data[i+1];
		end

		spdq_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.pos   (pos),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

FILE: sv/sign_partitioned_deque.sv
// ----------------------------------------------------------------------------
// sign_partitioned_deque
// Deque of up to DEPTH signed values kept ordered as negatives, zeros, then
// positives, with front and back removal.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock and answers each with exactly one
// result, registered in the cycle after the input transfer; a stalled output holds
// the input only once its single result register is full. The entries live in
// two rows of DEPTH chained cells, one in front-to-back order and one in
// back-to-front order, so both ends of the sequence always sit in cell 0 of a
// row. Any insert (front, back or just after the last negative) or removal
// completes with the cells moving their entries to neighbors in parallel.
// entry_count reports the low 7 bits of the number of held entries.
// Status is done, empty on a removal from an empty deque, or full on a
// dropped insert; the unused action code changes nothing and reports done.
module sign_partitioned_deque #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] removed_value, [38:32] entry_count
	output logic [1:0]  m_tuser    // [1:0] status
);
	import spdq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     neg_q;
	logic [CW-1:0]     count_next;
	logic [CW-1:0]     neg_next;
	logic [CW-1:0]     count_dec;
	logic [CW-1:0]     zero_pos;
	logic [CW-1:0]     zero_rev;

	logic              xfer_in;
	logic [DATA_W-1:0] value_w;
	logic              is_neg;
	logic              is_zero;

	cell_ctrl_t        fwd_ctrl;
	cell_ctrl_t        rev_ctrl;
	logic [IW-1:0]     fwd_pos;
	logic [IW-1:0]     rev_pos;
	logic [DATA_W-1:0] fwd_head;
	logic [DATA_W-1:0] rev_head;

	logic [DATA_W-1:0] removed_w;
	logic [STATUS_W-1:0] status_w;
	logic [CW+COUNT_W-1:0] count_ext;

	logic              m_tvalid_q;
	logic [39:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign xfer_in  = s_tvalid && s_tready;
	assign value_w  = s_tdata;
	assign is_neg   = value_w[DATA_W-1];
	assign is_zero  = (value_w == '0);
	assign count_dec = count_q - CW'(1);
	assign zero_pos  = (neg_q > count_q) ? count_q : neg_q;
	assign zero_rev  = count_q - zero_pos;

	always_comb begin
		fwd_ctrl   = '{op: OP_HOLD, data: value_w};
		rev_ctrl   = '{op: OP_HOLD, data: value_w};
		fwd_pos    = '0;
		rev_pos    = '0;
		count_next = count_q;
		neg_next   = neg_q;
		removed_w  = '0;
		status_w   = ST_DONE;
		unique case (s_tuser)
			ACT_INSERT: begin
				if (count_q == FULL_COUNT) begin
					status_w = ST_FULL;
				end else begin
					count_next   = count_q + CW'(1);
					fwd_ctrl.op  = OP_INSERT;
					rev_ctrl.op  = OP_INSERT;
					if (is_neg) begin
						fwd_pos  = '0;
						rev_pos  = count_q[IW-1:0];
						neg_next = neg_q + CW'(1);
					end else if (is_zero) begin
						// The reversed row sees the zero slot counted from the back.
						fwd_pos = zero_pos[IW-1:0];
						rev_pos = zero_rev[IW-1:0];
					end else begin
						fwd_pos = count_q[IW-1:0];
						rev_pos = '0;
					end
				end
			end
			ACT_POP_FRONT: begin
				if (count_q == '0) begin
					status_w = ST_EMPTY;
				end else begin
					removed_w   = fwd_head;
					fwd_ctrl.op = OP_SHIFT;
					count_next  = count_dec;
					if (neg_q != '0) begin
						neg_next = neg_q - CW'(1);
					end
				end
			end
			ACT_POP_BACK: begin
				if (count_q == '0) begin
					status_w = ST_EMPTY;
				end else begin
					removed_w   = rev_head;
					rev_ctrl.op = OP_SHIFT;
					count_next  = count_dec;
					if (neg_q > count_dec) begin
						neg_next = count_dec;
					end
				end
			end
			default: begin
				status_w = ST_DONE;
			end
		endcase
		if (!xfer_in) begin
			fwd_ctrl.op = OP_HOLD;
			rev_ctrl.op = OP_HOLD;
		end
	end

	assign count_ext = {{COUNT_W{1'b0}}, count_next};

	spdq_row #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_fwd_row (
		.clk  (clk),
		.ctrl (fwd_ctrl),
		.pos  (fwd_pos),
		.head (fwd_head)
	);

	spdq_row #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_rev_row (
		.clk  (clk),
		.ctrl (rev_ctrl),
		.pos  (rev_pos),
		.head (rev_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			neg_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (xfer_in) begin
				count_q    <= count_next;
				neg_q      <= neg_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer_in) begin
			m_tdata_q <= {1'b0, count_ext[COUNT_W-1:0], removed_w};
			m_tuser_q <= status_w;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: sim/sign_partitioned_deque_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_partitioned_deque_test
// Self-checking bench for the sign-partitioned deque. A scoreboard keeps its
// own model of the ordered store (negatives, zeros, positives) and predicts
// the removed value, status and entry count of every transfer. Stimulus is a
// short directed pass over the corner cases, then random phases that lean
// toward inserts or removals so that the store fills and drains repeatedly.
// ----------------------------------------------------------------------------
module sign_partitioned_deque_test;

	import spdq_pkg::*;

	localparam int DEPTH = 64;
	localparam int ITEM_TARGET = 1750;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic signed [DATA_W-1:0] removed;
		logic [STATUS_W-1:0]      status;
		logic [COUNT_W-1:0]       count;
	} deque_result_t;

	class deque_scoreboard;
		logic signed [DATA_W-1:0] contents[$];
		int unsigned              neg_held;
		int unsigned              capacity;
		deque_result_t            expected_q[$];
		int unsigned              failures;

		function new(int unsigned depth);
			capacity = depth;
			neg_held = 0;
			failures = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Applies one accepted input transfer to the store and queues its result.
		function void note_input(logic [ACTION_W-1:0] act, logic signed [DATA_W-1:0] val);
			deque_result_t r;
			int unsigned   pos;
			r.removed = '0;
			r.status = ST_DONE;
			case (act)
				ACT_INSERT: begin
					if (contents.size() >= capacity) begin
						r.status = ST_FULL;
					end else if (val[DATA_W-1]) begin
						contents.push_front(val);
						neg_held++;
					end else if (val == 0) begin
						pos = (neg_held > contents.size()) ? contents.size() : neg_held;
						contents.insert(pos, val);
					end else begin
						contents.push_back(val);
					end
				end
				ACT_POP_FRONT: begin
					if (contents.size() == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.removed = contents.pop_front();
						if (neg_held > 0)
							neg_held--;
					end
				end
				ACT_POP_BACK: begin
					if (contents.size() == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.removed = contents.pop_back();
						if (neg_held > contents.size())
							neg_held = contents.size();
					end
				end
				default: ;
			endcase
			r.count = COUNT_W'(contents.size());
			expected_q.push_back(r);
		endfunction

		function void check_result(logic signed [DATA_W-1:0] removed,
				logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
			deque_result_t e;
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected: removed_value %0d status %0d",
					removed, status);
				failures++;
				return;
			end
			e = expected_q.pop_front();
			if (removed !== e.removed) begin
				$error("removed_value: expected %0d, actual %0d", e.removed, removed);
				failures++;
			end
			if (status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, status);
				failures++;
			end
			if (count !== e.count) begin
				$error("entry_count: expected %0d, actual %0d", e.count, count);
				failures++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] value
	logic [1:0]  s_tuser = '0;   // [1:0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [31:0] removed_value, [38:32] entry_count
	logic [1:0]  m_tuser;        // [1:0] status
	logic        no_idle = 1'b0;
	int          stall_cycles = 0;

	deque_scoreboard sb = new(DEPTH);

	sign_partitioned_deque #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 19);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata[31:0], m_tuser, m_tdata[38:32]);
	end

	// Ends the run if the block stops taking or returning transfers.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [31:0] val);
		while (!no_idle && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
		sb.note_input(act, val);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			4: v = '0;
			5: v = 32'hFFFF_FFFF - $urandom_range(0, 15);
			6: v = $urandom_range(1, 16);
			7: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'hFFFF_FFFF;
					default: v = 32'd1;
				endcase
			end
			8: v[31] = 1'b1;
			9: begin
				v[31] = 1'b0;
				if (v == 0)
					v = 32'd1;
			end
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		int                  sent;
		int                  phase_left;
		int                  insert_pct;
		int                  roll;
		logic [ACTION_W-1:0] act;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass: empty removals, the unused code, sign extremes, zero
		// placement between negatives and positives, and removal from both ends.
		send_item(ACT_POP_FRONT, 32'hFFFF_FFFF);
		send_item(ACT_POP_BACK, 32'h0000_0000);
		send_item(ACT_UNUSED, 32'h1234_5678);
		send_item(ACT_INSERT, 32'h0000_0000);
		send_item(ACT_INSERT, 32'h8000_0000);
		send_item(ACT_INSERT, 32'h7FFF_FFFF);
		send_item(ACT_INSERT, 32'hFFFF_FFFF);
		send_item(ACT_INSERT, 32'h0000_0001);
		send_item(ACT_INSERT, 32'h0000_0000);
		send_item(ACT_INSERT, 32'hAAAA_AAAA);
		send_item(ACT_INSERT, 32'h5555_5555);
		send_item(ACT_UNUSED, 32'hFFFF_FFFF);
		send_item(ACT_POP_FRONT, 32'h0000_0000);
		send_item(ACT_POP_BACK, 32'hFFFF_FFFF);
		send_item(ACT_POP_BACK, 32'h0000_0000);
		send_item(ACT_POP_FRONT, 32'h0000_0000);
		send_item(ACT_POP_BACK, 32'h0000_0000);
		send_item(ACT_POP_BACK, 32'h0000_0000);
		send_item(ACT_POP_FRONT, 32'h0000_0000);
		send_item(ACT_POP_FRONT, 32'h0000_0000);
		send_item(ACT_POP_BACK, 32'h0000_0000);
		send_item(ACT_POP_FRONT, 32'h0000_0000);
		wait_for_drain();

		// The opening random phase fills the store well past full.
		sent = 22;
		phase_left = 90;
		insert_pct = 100;
		while (sent < ITEM_TARGET) begin
			if (phase_left <= 0) begin
				phase_left = $urandom_range(20, 120);
				case ($urandom_range(0, 2))
					0: insert_pct = 85;
					1: insert_pct = 50;
					default: insert_pct = 15;
				endcase
			end
			if (sent == ITEM_TARGET / 2)
				wait_for_drain();
			no_idle <= (sent >= 700 && sent < 1000);
			roll = $urandom_range(0, 99);
			if (roll < 2)
				act = ACT_UNUSED;
			else if (roll < insert_pct)
				act = ACT_INSERT;
			else if ($urandom_range(0, 1))
				act = ACT_POP_FRONT;
			else
				act = ACT_POP_BACK;
			send_item(act, (act == ACT_INSERT) ? pick_value() : 32'($urandom));
			if (act != ACT_UNUSED)
				sent++;
			phase_left--;
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
